@@ src/bprq_pkg.sv @@
package bprq_pkg;

   localparam int TASK_SLOTS_DEF = 64;
   localparam int TOP_LEVEL_DEF  = 63;

   typedef enum logic [2:0] {
      OP_ENQUEUE = 3'd0,
      OP_DEQUEUE = 3'd1,
      OP_PEEK    = 3'd2,
      OP_REMOVE  = 3'd3,
      OP_MOVE    = 3'd4,
      OP_CLEAR   = 3'd5
   } op_type;

   typedef enum logic [1:0] {
      ST_DONE   = 2'd0,
      ST_QUEUED = 2'd1,
      ST_NONE   = 2'd2
   } status_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_DECODE,
      S_FIND_GRP,
      S_FIND_BIT,
      S_RD_ENDS,
      S_RD_LINKS,
      S_UNLINK,
      S_RD_TAIL,
      S_LINK,
      S_RESP
   } state_type;

   typedef struct packed {
      logic       latch_req;
      logic       clear;
      logic       find_grp;
      logic       find_bit;
      logic       rd_ends;
      logic       ends_from_top;
      logic       rd_links;
      logic       links_from_head;
      logic       unlink;
      logic       rd_tail;
      logic       link;
      logic       rsp_load;
      logic       rsp_pick_valid;
      status_type rsp_status;
   } cmd_type;

   typedef struct packed {
      logic flag;
      logic noop;
      logic found;
   } sts_type;

endpackage

@@ src/bprq_ctrl.sv @@
module bprq_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  logic [2:0]        req_op,
   output logic              req_stall,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   input  bprq_pkg::sts_type sts,
   output bprq_pkg::cmd_type cmd
);
   import bprq_pkg::*;

   state_type  state_ff, state_in;
   op_type     op_ff, op_in;
   status_type status_ff, status_in;
   logic       pickv_ff, pickv_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       accept;
   logic       out_free;

   assign req_stall = (state_ff != S_IDLE);
   assign accept    = req_valid && !req_stall;
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid = rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         op_ff        <= OP_ENQUEUE;
         status_ff    <= ST_DONE;
         pickv_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         op_ff        <= op_in;
         status_ff    <= status_in;
         pickv_ff     <= pickv_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in     = state_ff;
      op_in        = op_ff;
      status_in    = status_ff;
      pickv_in     = pickv_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               op_in    = op_type'(req_op);
               state_in = S_DECODE;
            end
         end
         S_DECODE: begin
            status_in = ST_DONE;
            pickv_in  = 1'b0;
            unique case (op_ff)
               OP_ENQUEUE: begin
                  if (sts.flag) begin
                     status_in = ST_QUEUED;
                     state_in  = S_RESP;
                  end else begin
                     state_in = S_RD_TAIL;
                  end
               end
               OP_DEQUEUE, OP_PEEK: state_in = S_FIND_GRP;
               OP_REMOVE: begin
                  if (sts.flag) begin
                     state_in = S_RD_LINKS;
                  end else begin
                     status_in = ST_NONE;
                     state_in  = S_RESP;
                  end
               end
               OP_MOVE: begin
                  priority if (sts.noop) state_in = S_RESP;
                  else if (sts.flag)     state_in = S_RD_LINKS;
                  else                   state_in = S_RD_TAIL;
               end
               default: state_in = S_RESP;
            endcase
         end
         S_FIND_GRP: begin
            if (sts.found) begin
               state_in = S_FIND_BIT;
            end else begin
               status_in = ST_NONE;
               state_in  = S_RESP;
            end
         end
         S_FIND_BIT: state_in = S_RD_ENDS;
         S_RD_ENDS: begin
            priority if (op_ff == OP_PEEK) begin
               pickv_in = 1'b1;
               state_in = S_RESP;
            end else if (op_ff == OP_DEQUEUE) begin
               pickv_in = 1'b1;
               state_in = S_RD_LINKS;
            end else begin
               state_in = S_UNLINK;
            end
         end
         S_RD_LINKS: state_in = (op_ff == OP_DEQUEUE) ? S_UNLINK : S_RD_ENDS;
         S_UNLINK:   state_in = (op_ff == OP_MOVE) ? S_RD_TAIL : S_RESP;
         S_RD_TAIL:  state_in = S_LINK;
         S_LINK:     state_in = S_RESP;
         S_RESP: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      cmd                 = '0;
      cmd.rsp_status      = status_ff;
      cmd.rsp_pick_valid  = pickv_ff;
      cmd.ends_from_top   = (op_ff == OP_DEQUEUE) || (op_ff == OP_PEEK);
      cmd.links_from_head = (op_ff == OP_DEQUEUE);
      unique case (state_ff)
         S_IDLE:     cmd.latch_req = accept;
         S_DECODE:   cmd.clear     = (op_ff == OP_CLEAR);
         S_FIND_GRP: cmd.find_grp  = 1'b1;
         S_FIND_BIT: cmd.find_bit  = 1'b1;
         S_RD_ENDS:  cmd.rd_ends   = 1'b1;
         S_RD_LINKS: cmd.rd_links  = 1'b1;
         S_UNLINK:   cmd.unlink    = 1'b1;
         S_RD_TAIL:  cmd.rd_tail   = 1'b1;
         S_LINK:     cmd.link      = 1'b1;
         S_RESP:     cmd.rsp_load  = out_free;
         default:    cmd.latch_req = 1'b0;
      endcase
   end

   a_load_valid: assert property (@(posedge clock) disable iff (reset)
      cmd.rsp_load |=> rsp_valid_ff)
      else $error("response not raised after load");
   a_accept_decode: assert property (@(posedge clock) disable iff (reset)
      accept |=> state_ff == S_DECODE)
      else $error("accepted word not decoded");
   a_pick_done: assert property (@(posedge clock) disable iff (reset)
      (cmd.rsp_load && cmd.rsp_pick_valid) |-> cmd.rsp_status == ST_DONE)
      else $error("picked task with failing status");

endmodule

@@ src/bprq_dp.sv @@
module bprq_dp #(
   parameter int TASK_SLOTS = bprq_pkg::TASK_SLOTS_DEF,
   parameter int TOP_LEVEL  = bprq_pkg::TOP_LEVEL_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic [5:0]           req_task_slot,
   input  logic [5:0]           req_level,
   input  logic [5:0]           req_old_level,
   input  bprq_pkg::cmd_type    cmd,
   output bprq_pkg::sts_type    sts,
   output logic [5:0]           rsp_picked_task,
   output logic                 rsp_picked_valid,
   output logic [1:0]           rsp_status
);
   import bprq_pkg::*;

   // only 64 slots are reachable through a 6-bit task field
   localparam int SLOTS = (TASK_SLOTS < 64) ? TASK_SLOTS : 64;
   localparam int SW    = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int NLEV  = TOP_LEVEL + 1;
   localparam int LW    = $clog2(NLEV);
   localparam int NG    = (NLEV + 15) / 16;
   localparam int GW    = (NG > 1) ? $clog2(NG) : 1;

   logic [SW-1:0] next_mem [SLOTS];
   logic [SW-1:0] prev_mem [SLOTS];
   logic [LW-1:0] tlev_mem [SLOTS];
   logic [SW-1:0] head_mem [NLEV];
   logic [SW-1:0] tail_mem [NLEV];

   logic [SW-1:0]    slot_ff, ut_ff, prev_q, next_q, head_q, tail_q;
   logic [LW-1:0]    lvl_ff, ulv_ff, top_ff, tlev_q;
   logic             noop_ff;
   logic [GW-1:0]    grp_ff;
   logic [SLOTS-1:0] qflag_ff;
   logic [NLEV-1:0]  bm_ff;
   logic [5:0]       rsp_task_ff;
   logic             rsp_pv_ff;
   status_type       rsp_st_ff;

   logic [SW-1:0]    slot_mod;
   logic [LW-1:0]    lvl_sat;
   logic [NG*16-1:0] bm_pad;
   logic [NG-1:0]    grp_any;
   logic [GW-1:0]    grp_sel;
   logic [15:0]      grp_bits;
   logic [3:0]       bit_sel;
   logic [LW-1:0]    ends_addr;
   logic [SW-1:0]    links_addr;
   logic             is_head, is_tail, bm_hit;

   always_comb begin
      slot_mod = '0;
      for (int k = 0; k < 64; k++) begin
         if (req_task_slot == 6'(k)) slot_mod = SW'(k % TASK_SLOTS);
      end
   end

   assign lvl_sat = (32'(req_level) > TOP_LEVEL) ? LW'(TOP_LEVEL) : LW'(req_level);

   always_comb begin
      bm_pad = '0;
      bm_pad[NLEV-1:0] = bm_ff;
   end

   always_comb begin
      for (int g = 0; g < NG; g++) grp_any[g] = |bm_pad[g*16 +: 16];
   end

   // highest non-empty group, then highest bit inside it
   always_comb begin
      grp_sel = '0;
      for (int g = 0; g < NG; g++) begin
         if (grp_any[g]) grp_sel = GW'(g);
      end
   end

   assign grp_bits = bm_pad[grp_ff*16 +: 16];

   always_comb begin
      bit_sel = '0;
      for (int b = 0; b < 16; b++) begin
         if (grp_bits[b]) bit_sel = 4'(b);
      end
   end

   assign ends_addr  = cmd.ends_from_top ? top_ff : tlev_q;
   assign links_addr = cmd.links_from_head ? head_q : slot_ff;
   assign is_head    = (head_q == ut_ff);
   assign is_tail    = (tail_q == ut_ff);
   assign bm_hit     = bm_ff[lvl_ff];

   assign sts.flag  = qflag_ff[slot_ff];
   assign sts.noop  = noop_ff;
   assign sts.found = |grp_any;

   always_ff @(posedge clock) begin
      if (cmd.latch_req) begin
         slot_ff <= slot_mod;
         lvl_ff  <= lvl_sat;
         noop_ff <= (req_old_level == req_level);
      end
      if (cmd.find_grp) grp_ff <= grp_sel;
      if (cmd.find_bit) top_ff <= LW'({grp_ff, bit_sel});
      if (cmd.rd_ends) ulv_ff <= ends_addr;
      if (cmd.rd_links) ut_ff <= links_addr;
      if (cmd.rsp_load) begin
         rsp_task_ff <= cmd.rsp_pick_valid ? 6'(head_q) : 6'd0;
         rsp_pv_ff   <= cmd.rsp_pick_valid;
         rsp_st_ff   <= cmd.rsp_status;
      end
   end

   // link memories: one read and one write port each
   always_ff @(posedge clock) begin
      if (cmd.rd_links) begin
         next_q <= next_mem[links_addr];
         prev_q <= prev_mem[links_addr];
         tlev_q <= tlev_mem[links_addr];
      end
      if (cmd.rd_ends) head_q <= head_mem[ends_addr];
      if (cmd.rd_ends) begin
         tail_q <= tail_mem[ends_addr];
      end else if (cmd.rd_tail) begin
         tail_q <= tail_mem[lvl_ff];
      end
      if (cmd.unlink) begin
         priority if (is_head && is_tail) begin
         end else if (is_head) begin
            head_mem[ulv_ff] <= next_q;
         end else if (is_tail) begin
            tail_mem[ulv_ff] <= prev_q;
         end else begin
            next_mem[prev_q] <= next_q;
            prev_mem[next_q] <= prev_q;
         end
      end
      if (cmd.link) begin
         tlev_mem[slot_ff] <= lvl_ff;
         tail_mem[lvl_ff]  <= slot_ff;
         if (bm_hit) begin
            next_mem[tail_q]  <= slot_ff;
            prev_mem[slot_ff] <= tail_q;
         end else begin
            head_mem[lvl_ff] <= slot_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         qflag_ff <= '0;
         bm_ff    <= '0;
      end else if (cmd.clear) begin
         qflag_ff <= '0;
         bm_ff    <= '0;
      end else begin
         if (cmd.unlink) begin
            qflag_ff[ut_ff] <= 1'b0;
            if (is_head && is_tail) bm_ff[ulv_ff] <= 1'b0;
         end
         if (cmd.link) begin
            qflag_ff[slot_ff] <= 1'b1;
            bm_ff[lvl_ff]     <= 1'b1;
         end
      end
   end

   assign rsp_picked_task  = rsp_task_ff;
   assign rsp_picked_valid = rsp_pv_ff;
   assign rsp_status       = rsp_st_ff;

   a_link_flag: assert property (@(posedge clock) disable iff (reset)
      cmd.link |=> qflag_ff[$past(slot_ff)])
      else $error("linked task not flagged");
   a_link_level: assert property (@(posedge clock) disable iff (reset)
      cmd.link |=> bm_ff[$past(lvl_ff)])
      else $error("level not marked after link");
   a_clear: assert property (@(posedge clock) disable iff (reset)
      cmd.clear |=> (bm_ff == '0) && (qflag_ff == '0))
      else $error("clear left state behind");

endmodule

@@ src/bitmap_priority_ready_queue.sv @@
// channel | ports                                              | direction
// req     | req_valid req_stall req_op req_task_slot req_level | in
//         | req_old_level                                      |
// rsp     | rsp_valid rsp_stall rsp_picked_task                | out
//         | rsp_picked_valid rsp_status                        |
// one word at a time; clear, refused or trivial ops take the shortest path, a dequeue
// or a move of a queued task the longest, set by the dependent reads of the link
// memories and the two-step bitmap search
// synchronous reset clears queued flags, level bitmap and control; link memories
// need no clearing. req_stall is high while a word is in work; a response held
// by rsp_stall lets the next word in, and its result waits for the slot
module bitmap_priority_ready_queue #(
   parameter int TASK_SLOTS = bprq_pkg::TASK_SLOTS_DEF,
   parameter int TOP_LEVEL  = bprq_pkg::TOP_LEVEL_DEF
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [2:0] req_op,
   input  logic [5:0] req_task_slot,
   input  logic [5:0] req_level,
   input  logic [5:0] req_old_level,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [5:0] rsp_picked_task,
   output logic       rsp_picked_valid,
   output logic [1:0] rsp_status
);
   import bprq_pkg::*;

   cmd_type cmd;
   sts_type sts;

   bprq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_op    (req_op),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   bprq_dp #(
      .TASK_SLOTS (TASK_SLOTS),
      .TOP_LEVEL  (TOP_LEVEL)
   ) u_dp (
      .clock            (clock),
      .reset            (reset),
      .req_task_slot    (req_task_slot),
      .req_level        (req_level),
      .req_old_level    (req_old_level),
      .cmd              (cmd),
      .sts              (sts),
      .rsp_picked_task  (rsp_picked_task),
      .rsp_picked_valid (rsp_picked_valid),
      .rsp_status       (rsp_status)
   );

endmodule

@@ sim/testbench.sv @@
`timescale 1ns / 1ps

module testbench;
   import bprq_pkg::*;

   localparam int SLOTS = 64;
   localparam int LEVELS = 64;
   localparam int STALL_LIMIT = 20000;

   typedef struct packed {
      logic [5:0] picked_task;
      logic       picked_valid;
      logic [1:0] status;
   } word_type;

   class ready_queue_board;
      logic [5:0] nxt[SLOTS];
      logic [5:0] prv[SLOTS];
      bit         queued[SLOTS];
      logic [5:0] lvl_of[SLOTS];
      logic [5:0] head[LEVELS];
      logic [5:0] tail[LEVELS];
      logic [63:0] busy_levels;
      word_type   pending[$];
      int         errors;

      function void reset_state();
         int i;
         for (i = 0; i < SLOTS; i++) begin
            queued[i] = 0;
            lvl_of[i] = 0;
         end
         busy_levels = '0;
         pending.delete();
         errors = 0;
      endfunction

      function void append(logic [5:0] t, logic [5:0] lv);
         if (busy_levels[lv]) begin
            nxt[tail[lv]] = t;
            prv[t] = tail[lv];
         end else begin
            head[lv] = t;
            prv[t] = t;
            busy_levels[lv] = 1'b1;
         end
         nxt[t] = t;
         tail[lv] = t;
         queued[t] = 1;
         lvl_of[t] = lv;
      endfunction

      function void detach(logic [5:0] t);
         logic [5:0] lv, p, n;
         bit at_head, at_tail;
         lv = lvl_of[t];
         at_head = head[lv] == t;
         at_tail = tail[lv] == t;
         p = prv[t];
         n = nxt[t];
         if (at_head && at_tail) busy_levels[lv] = 1'b0;
         else if (at_head) head[lv] = n;
         else if (at_tail) begin
            tail[lv] = p;
            nxt[p] = p;
         end else begin
            nxt[p] = n;
            prv[n] = p;
         end
         queued[t] = 0;
         lvl_of[t] = 0;
      endfunction

      function void note_request(logic [2:0] op, logic [5:0] t, logic [5:0] lv,
                                 logic [5:0] old_lv);
         word_type w;
         int top, i;
         w = '0;
         w.status = ST_DONE;
         case (op)
            OP_ENQUEUE: begin
               if (queued[t]) w.status = ST_QUEUED;
               else append(t, lv);
            end
            OP_DEQUEUE, OP_PEEK: begin
               top = -1;
               for (i = LEVELS - 1; i >= 0 && top < 0; i--)
                  if (busy_levels[i]) top = i;
               if (top < 0) w.status = ST_NONE;
               else begin
                  w.picked_task = head[top];
                  w.picked_valid = 1'b1;
                  if (op == OP_DEQUEUE) detach(head[top]);
               end
            end
            OP_REMOVE: begin
               if (queued[t]) detach(t);
               else begin
                  lvl_of[t] = 0;
                  w.status = ST_NONE;
               end
            end
            OP_MOVE: begin
               if (old_lv != lv) begin
                  if (queued[t]) detach(t);
                  append(t, lv);
               end
            end
            OP_CLEAR: begin
               for (i = 0; i < SLOTS; i++) begin
                  queued[i] = 0;
                  lvl_of[i] = 0;
               end
               busy_levels = '0;
            end
            default: ;
         endcase
         pending = {pending, w};
      endfunction

      function void check_word(word_type got);
         word_type want;
         if (pending.size() == 0) begin
            $display("%0t: unexpected word exp none act %p", $time, got);
            errors++;
            return;
         end
         want = pending[0];
         pending.delete(0);
         if (got.picked_task !== want.picked_task) begin
            $display("%0t: picked_task exp %0d act %0d", $time, want.picked_task,
                     got.picked_task);
            errors++;
         end
         if (got.picked_valid !== want.picked_valid) begin
            $display("%0t: picked_valid exp %0d act %0d", $time, want.picked_valid,
                     got.picked_valid);
            errors++;
         end
         if (got.status !== want.status) begin
            $display("%0t: status exp %0d act %0d", $time, want.status, got.status);
            errors++;
         end
      endfunction
   endclass

   logic       clock;
   logic       reset;
   logic       req_valid;
   logic       req_stall;
   logic [2:0] req_op;
   logic [5:0] req_task_slot;
   logic [5:0] req_level;
   logic [5:0] req_old_level;
   logic       rsp_valid;
   logic       rsp_stall;
   logic [5:0] rsp_picked_task;
   logic       rsp_picked_valid;
   logic [1:0] rsp_status;

   ready_queue_board board;
   int  send_idle_pct;
   int  recv_idle_pct;
   int  quiet_cycles;

   bitmap_priority_ready_queue dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_op(req_op),
      .req_task_slot(req_task_slot), .req_level(req_level),
      .req_old_level(req_old_level),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_picked_task(rsp_picked_task), .rsp_picked_valid(rsp_picked_valid),
      .rsp_status(rsp_status)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // receiver side: random stall and result checking
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
         quiet_cycles <= 0;
      end else begin
         if (rsp_valid && !rsp_stall)
            board.check_word({rsp_picked_task, rsp_picked_valid, rsp_status});
         rsp_stall <= ($urandom_range(99) < recv_idle_pct);
         if ((rsp_valid && !rsp_stall) || (req_valid && !req_stall))
            quiet_cycles <= 0;
         else if (board.pending.size() != 0 || req_valid)
            quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= STALL_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
         end
      end
   end

   // valid stays up after an accept until the next word or an idle cycle
   task automatic send_word(logic [2:0] op, logic [5:0] t, logic [5:0] lv,
                            logic [5:0] old_lv);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_op <= op;
      req_task_slot <= t;
      req_level <= lv;
      req_old_level <= old_lv;
      do @(posedge clock); while (req_stall);
      board.note_request(op, t, lv, old_lv);
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      while (board.pending.size() != 0) @(posedge clock);
   endtask

   // mostly well-formed traffic over a small set of tasks so queues get deep
   task automatic random_phase(int count);
      int k, pick;
      logic [5:0] t, lv;
      for (k = 0; k < count; k++) begin
         pick = $urandom_range(99);
         t = (pick < 85) ? 6'($urandom_range(15)) : 6'($urandom);
         lv = (pick < 60) ? 6'($urandom_range(7)) : 6'($urandom);
         if (pick < 35) send_word(OP_ENQUEUE, t, lv, 6'($urandom));
         else if (pick < 55) send_word(OP_DEQUEUE, 6'($urandom), 6'($urandom), 6'($urandom));
         else if (pick < 63) send_word(OP_PEEK, 6'($urandom), 6'($urandom), 6'($urandom));
         else if (pick < 76) send_word(OP_REMOVE, t, 6'($urandom), 6'($urandom));
         else if (pick < 92)
            send_word(OP_MOVE, t, lv, ($urandom_range(9) == 0) ? lv : 6'($urandom));
         else if (pick < 94) send_word(OP_CLEAR, t, lv, 6'($urandom));
         else send_word(3'($urandom_range(7)), 6'($urandom), 6'($urandom), 6'($urandom));
      end
   endtask

   initial begin
      board = new();
      board.reset_state();
      reset = 1'b1;
      req_valid = 1'b0;
      req_op = OP_ENQUEUE;
      req_task_slot = '0;
      req_level = '0;
      req_old_level = '0;
      send_idle_pct = 0;
      recv_idle_pct = 0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed corners
      send_word(OP_DEQUEUE, 6'd0, 6'd0, 6'd0);
      send_word(OP_PEEK, 6'd63, 6'd63, 6'd63);
      send_word(OP_REMOVE, 6'd5, 6'd0, 6'd0);
      send_word(OP_ENQUEUE, 6'd0, 6'd0, 6'd0);
      send_word(OP_ENQUEUE, 6'd63, 6'd63, 6'd0);
      send_word(OP_ENQUEUE, 6'd63, 6'd1, 6'd0);
      send_word(OP_ENQUEUE, 6'd10, 6'd63, 6'd0);
      send_word(OP_ENQUEUE, 6'd11, 6'd63, 6'd0);
      send_word(OP_PEEK, 6'd0, 6'd0, 6'd0);
      send_word(OP_REMOVE, 6'd10, 6'd0, 6'd0);
      send_word(OP_MOVE, 6'd11, 6'd7, 6'd7);
      send_word(OP_MOVE, 6'd11, 6'd0, 6'd63);
      send_word(OP_MOVE, 6'd20, 6'd42, 6'd21);
      send_word(3'd6, 6'd63, 6'd63, 6'd63);
      send_word(3'd7, 6'd0, 6'd0, 6'd0);
      send_word(OP_DEQUEUE, 6'd0, 6'd0, 6'd0);
      send_word(OP_DEQUEUE, 6'd0, 6'd0, 6'd0);
      send_word(OP_CLEAR, 6'd0, 6'd0, 6'd0);
      send_word(OP_PEEK, 6'd0, 6'd0, 6'd0);
      send_word(OP_ENQUEUE, 6'd0, 6'd0, 6'd0);
      send_word(OP_DEQUEUE, 6'd0, 6'd0, 6'd0);
      wait_drained();

      send_idle_pct = 31;
      recv_idle_pct = 78;
      random_phase(580);
      wait_drained();
      send_idle_pct = 78;
      recv_idle_pct = 31;
      random_phase(580);
      send_idle_pct = 0;
      recv_idle_pct = 0;
      random_phase(580);

      wait_drained();
      repeat (20) @(posedge clock);
      if (board.errors == 0 && board.pending.size() == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule

@@ bitmap_priority_ready_queue.f @@
src/bprq_pkg.sv
src/bprq_ctrl.sv
src/bprq_dp.sv
src/bitmap_priority_ready_queue.sv
sim/testbench.sv
